// File: sv/bgsa_pkg.sv
package bgsa_pkg;

  // Level and register widths.
  localparam int LVL_W  = 32;
  localparam int SENS_W = 32;
  localparam int FALL_W = 16;
  localparam int W_W    = 16;
  localparam int G_W    = 24;
  localparam int BC_W   = 9;
  localparam int CFG_W  = 32;
  localparam int IDX_W  = 3;

  // Fixed-point constants, Q16.16 or Q0.16.
  localparam logic [16:0]       ONE_Q16      = 17'd65536;
  localparam logic [FALL_W-1:0] FALL_STEP    = 16'd1835;
  localparam logic [LVL_W-1:0]  LEVEL_FLOOR  = 32'd66;
  localparam logic [16:0]       SENS_DOWN    = 17'd64225;
  localparam logic [16:0]       SENS_UP      = 17'd65602;
  localparam logic [W_W-1:0]    WEIGHT_TENTH = 16'd6553;

  // Register reset values.
  localparam logic [BC_W-1:0]   RST_BAR_COUNT = 9'd64;
  localparam logic [W_W-1:0]    RST_WEIGHT    = 16'd50463;
  localparam logic [G_W-1:0]    RST_GRAVITY   = 24'd131072;
  localparam logic [LVL_W-1:0]  RST_GAIN      = 32'd65536;
  localparam logic [SENS_W-1:0] RST_SENS      = 32'd6553600;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_BAR_COUNT   = 3'd0,
    REG_AUTO_GAIN   = 3'd1,
    REG_WEIGHT      = 3'd2,
    REG_GRAVITY     = 3'd3,
    REG_OUT_GAIN    = 3'd4,
    REG_START_SENS  = 3'd5,
    REG_START_PHASE = 3'd6
  } reg_idx_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE, S_SENS, S_DECIDE, S_GRAV1, S_GRAV2, S_GRAV3,
    S_SM1, S_SM2, S_SM3, S_GAIN, S_OUT, S_ADJ, S_ADJ_APPLY
  } state_t;

  // Operand selection for the shared multiplier.
  typedef enum logic [2:0] {
    M_SENS, M_FF, M_FG, M_PEAK, M_MEMW, M_XW, M_GAIN, M_ADJ
  } mul_sel_t;

  typedef struct packed {
    logic       load_in;
    logic       decide;
    logic       grav2;
    logic       grav3;
    logic       sm2;
    logic       sm3;
    logic       out_load;
    logic       adj_apply;
    mul_sel_t   mul_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic fall;
    logic t_big;
    logic gain_one;
    logic out_free;
    logic adapt;
  } dp_stat_t;

  typedef struct packed {
    logic [BC_W-1:0]  bar_count;
    logic             auto_on;
    logic [W_W-1:0]   weight;
    logic [G_W-1:0]   gravity;
    logic [LVL_W-1:0] gain;
  } cfg_t;

  typedef struct packed {
    logic              sens_ld;
    logic              flag_ld;
    logic [CFG_W-1:0]  data;
  } cfg_wr_t;

  // Take a Q16.16 product back to 32 bits, saturating.
  function automatic logic [31:0] sat_q16(input logic [63:0] p);
    logic [31:0] r;
    r = (p[63:48] != 16'd0) ? 32'hFFFF_FFFF : p[47:16];
    return r;
  endfunction

endpackage

// File: sv/bar_gravity_smoothing_autogain_unit.sv
// Spectrum bar level unit: gravity fall-off, IIR smoothing and auto-gain.
// Input channel (in_valid/in_ready) takes one band energy per bar, bars in
// order from bar 0, together with the frame's signal-present flag. Result
// channel (out_valid/out_ready) returns one Q16.16 level per bar with its
// bar number and a frame-end mark on the last bar.
// Each bar passes through a single shared 32x32 multiplier, one product per
// cycle, sequenced by the controller. A result follows the sensitivity,
// decision and smoothing steps; a falling bar adds the gravity steps and a
// non-unity output gain adds a gain step. The input reopens in the cycle
// after the result is registered, or after the sensitivity adjust and apply
// steps on a frame end where the sensitivity adapts.
// A result waits in the output register while the receiver stalls; the next
// bar is worked on meanwhile and holds in its last step until it drains.
// Reset clears the per-bar valid bits, so every bar starts from zero, and
// loads the default registers and a sensitivity of 100.0.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// belong in idle time only.
module bar_gravity_smoothing_autogain_unit #(
  parameter int MAX_BARS    = 256,
  parameter int SENS_PERIOD = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bgsa_pkg::LVL_W-1:0]    in_band_energy,
  input  logic                          in_signal_present,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bgsa_pkg::LVL_W-1:0]    out_bar_level,
  output logic [7:0]                    out_bar_number,
  output logic                          out_frame_end,
  input  logic                          cfg_we,
  input  logic [bgsa_pkg::IDX_W-1:0]    cfg_index,
  input  logic [bgsa_pkg::CFG_W-1:0]    cfg_data
);
  import bgsa_pkg::*;

  cfg_t     cfg_r;
  cfg_wr_t  cfg_wr;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bar_count <= RST_BAR_COUNT;
      cfg_r.auto_on   <= 1'b1;
      cfg_r.weight    <= RST_WEIGHT;
      cfg_r.gravity   <= RST_GRAVITY;
      cfg_r.gain      <= RST_GAIN;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BAR_COUNT: cfg_r.bar_count <= cfg_data[BC_W-1:0];
        REG_AUTO_GAIN: cfg_r.auto_on   <= cfg_data[0];
        REG_WEIGHT:    cfg_r.weight    <= cfg_data[W_W-1:0];
        REG_GRAVITY:   cfg_r.gravity   <= cfg_data[G_W-1:0];
        REG_OUT_GAIN:  cfg_r.gain      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Writes that load the running sensitivity and its start flag.
  always_comb begin
    cfg_wr.sens_ld = cfg_we && (reg_idx_t'(cfg_index) == REG_START_SENS);
    cfg_wr.flag_ld = cfg_we && (reg_idx_t'(cfg_index) == REG_START_PHASE);
    cfg_wr.data    = cfg_data;
  end

  bgsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bgsa_dp #(
    .MAX_BARS    (MAX_BARS),
    .SENS_PERIOD (SENS_PERIOD)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .cfg_wr            (cfg_wr),
    .cmd               (cmd),
    .stat              (stat),
    .in_band_energy    (in_band_energy),
    .in_signal_present (in_signal_present),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_bar_level     (out_bar_level),
    .out_bar_number    (out_bar_number),
    .out_frame_end     (out_frame_end)
  );

endmodule

// File: sv/bgsa_ctrl.sv
module bgsa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bgsa_pkg::dp_stat_t stat,
  output bgsa_pkg::dp_cmd_t  cmd
);
  import bgsa_pkg::*;

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.mul_sel = M_SENS;
    in_ready    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_SENS;
        end
      end
      S_SENS: begin
        cmd.mul_sel = M_SENS;
        state_nxt   = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide  = 1'b1;
        cmd.mul_sel = M_FF;
        state_nxt   = stat.fall ? S_GRAV1 : S_SM1;
      end
      S_GRAV1: begin
        cmd.mul_sel = M_FG;
        state_nxt   = S_GRAV2;
      end
      S_GRAV2: begin
        cmd.grav2   = 1'b1;
        cmd.mul_sel = M_PEAK;
        state_nxt   = stat.t_big ? S_SM1 : S_GRAV3;
      end
      S_GRAV3: begin
        cmd.grav3 = 1'b1;
        state_nxt = S_SM1;
      end
      S_SM1: begin
        cmd.mul_sel = M_MEMW;
        state_nxt   = S_SM2;
      end
      S_SM2: begin
        cmd.sm2     = 1'b1;
        cmd.mul_sel = M_XW;
        state_nxt   = S_SM3;
      end
      S_SM3: begin
        cmd.sm3   = 1'b1;
        state_nxt = stat.gain_one ? S_OUT : S_GAIN;
      end
      S_GAIN: begin
        cmd.mul_sel = M_GAIN;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        cmd.mul_sel = M_GAIN;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = stat.adapt ? S_ADJ : S_IDLE;
        end
      end
      S_ADJ: begin
        cmd.mul_sel = M_ADJ;
        state_nxt   = S_ADJ_APPLY;
      end
      S_ADJ_APPLY: begin
        cmd.adj_apply = 1'b1;
        cmd.mul_sel   = M_ADJ;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/bgsa_dp.sv
module bgsa_dp #(
  parameter int MAX_BARS    = 256,
  parameter int SENS_PERIOD = 3
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bgsa_pkg::cfg_t                   cfg,
  input  bgsa_pkg::cfg_wr_t                cfg_wr,
  input  bgsa_pkg::dp_cmd_t                cmd,
  output bgsa_pkg::dp_stat_t               stat,
  input  logic [bgsa_pkg::LVL_W-1:0]       in_band_energy,
  input  logic                             in_signal_present,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bgsa_pkg::LVL_W-1:0]       out_bar_level,
  output logic [7:0]                       out_bar_number,
  output logic                             out_frame_end
);
  import bgsa_pkg::*;

  localparam int IW    = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
  localparam int CW    = (IW + 1 > BC_W) ? IW + 1 : BC_W;
  localparam int ROW_W = 3 * LVL_W + FALL_W;

  // Per-bar row: held peak, fall amount, previous raw level, smoothed level.
  logic [ROW_W-1:0]    mem [MAX_BARS];
  logic [MAX_BARS-1:0] vld_r;
  logic [ROW_W-1:0]    rd_r;
  logic                rd_vld_r;
  logic [ROW_W-1:0]    row;
  logic [LVL_W-1:0]    row_peak, row_prev, row_sm;
  logic [FALL_W-1:0]   row_fall;

  logic [IW-1:0]       pos_r;
  logic [LVL_W-1:0]    x_r, y_r, peak_n_r;
  logic [FALL_W-1:0]   fall_n_r;
  logic                sig_r, last_r, ovs_r, adj_dn_r;
  logic [47:0]         acc_r;
  logic [63:0]         prod_r;
  logic [SENS_W-1:0]   sens_r;
  logic                flag_r;
  logic [1:0]          phase_r;
  logic                out_valid_r;
  logic [LVL_W-1:0]    out_lvl_r;
  logic [IW-1:0]       out_num_r;
  logic                out_end_r;

  logic [CW-1:0]       bc, cnt0, cnt;
  logic                last_c;
  logic [LVL_W-1:0]    x1, lvl_c, sm_c;
  logic [G_W-1:0]      g_eff;
  logic [16:0]         w_inv;
  logic [48:0]         sum_c;
  logic [31:0]         mul_a, mul_b, adj_s, adj_dbl;
  logic [1:0]          phase_inc;
  logic                roll;
  logic [FALL_W:0]     fall_inc;

  assign row      = rd_vld_r ? rd_r : '0;
  assign row_peak = row[ROW_W-1 -: LVL_W];
  assign row_fall = row[2*LVL_W+FALL_W-1 -: FALL_W];
  assign row_prev = row[2*LVL_W-1 -: LVL_W];
  assign row_sm   = row[LVL_W-1:0];

  // Effective bar count and end-of-frame detection.
  always_comb begin
    bc     = CW'(cfg.bar_count);
    cnt0   = (bc == '0) ? CW'(1) : bc;
    cnt    = (cnt0 > CW'(MAX_BARS)) ? CW'(MAX_BARS) : cnt0;
    last_c = (CW'(pos_r) + CW'(1)) >= cnt;
  end

  // Operand selection and helper values.
  always_comb begin
    g_eff    = (cfg.gravity < G_W'(ONE_Q16)) ? G_W'(ONE_Q16) : cfg.gravity;
    w_inv    = ONE_Q16 - {1'b0, cfg.weight};
    x1       = cfg.auto_on ? sat_q16(prod_r) : x_r;
    fall_inc = {1'b0, row_fall} + {1'b0, FALL_STEP};
    sum_c    = {1'b0, acc_r} + {1'b0, prod_r[47:0]};
    lvl_c    = sum_c[48] ? '1 : sum_c[47:16];
    sm_c     = (!sig_r && lvl_c < LEVEL_FLOOR) ? LEVEL_FLOOR : lvl_c;
    adj_s    = sat_q16(prod_r);
    adj_dbl  = adj_s[31] ? 32'hFFFF_FFFF : {adj_s[30:0], 1'b0};
    mul_a    = x_r;
    mul_b    = sens_r;
    case (cmd.mul_sel)
      M_SENS: begin mul_a = x_r;                    mul_b = sens_r; end
      M_FF:   begin mul_a = 32'(row_fall);          mul_b = 32'(row_fall); end
      M_FG:   begin mul_a = 32'(prod_r[31:16]);     mul_b = 32'(g_eff); end
      M_PEAK: begin
        mul_a = row_peak;
        mul_b = 32'(ONE_Q16 - {1'b0, prod_r[31:16]});
      end
      M_MEMW: begin mul_a = row_sm;                 mul_b = 32'(cfg.weight); end
      M_XW:   begin mul_a = x_r;                    mul_b = 32'(w_inv); end
      M_GAIN: begin mul_a = y_r;                    mul_b = cfg.gain; end
      M_ADJ:  begin
        mul_a = sens_r;
        mul_b = adj_dn_r ? 32'(SENS_DOWN) : 32'(SENS_UP);
      end
      default: begin mul_a = x_r;                   mul_b = sens_r; end
    endcase
  end

  // Frame phase advance.
  always_comb begin
    phase_inc = phase_r + 2'd1;
    roll      = 32'(phase_inc) >= SENS_PERIOD;
  end

  // Status back to the controller.
  always_comb begin
    stat.fall     = (x1 < row_prev) && (cfg.weight > WEIGHT_TENTH);
    stat.t_big    = |prod_r[39:32];
    stat.gain_one = (cfg.gain == LVL_W'(ONE_Q16));
    stat.out_free = !out_valid_r || out_ready;
    stat.adapt    = last_r && cfg.auto_on && roll && (ovs_r || sig_r);
  end

  // Shared multiplier with registered product.
  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
  end

  // Per-bar store, registered read at the current bar.
  always_ff @(posedge clk) begin
    if (cmd.sm3) begin
      mem[pos_r] <= {peak_n_r, fall_n_r, x_r, sm_c};
    end
    rd_r <= mem[pos_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[pos_r];
      if (cmd.sm3) begin
        vld_r[pos_r] <= 1'b1;
      end
    end
  end

  // Working registers of the current bar.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_r    <= in_band_energy;
      sig_r  <= in_signal_present;
      last_r <= last_c;
    end
    if (cmd.decide) begin
      x_r <= x1;
      if (stat.fall) begin
        peak_n_r <= row_peak;
        fall_n_r <= fall_inc[FALL_W] ? '1 : fall_inc[FALL_W-1:0];
      end else begin
        peak_n_r <= x1;
        fall_n_r <= '0;
      end
    end
    if (cmd.grav2 && stat.t_big) begin
      x_r <= '0;
    end
    if (cmd.grav3) begin
      x_r <= prod_r[47:16];
    end
    if (cmd.sm2) begin
      acc_r <= prod_r[47:0];
    end
    if (cmd.sm3) begin
      y_r <= (cfg.auto_on && sm_c > LVL_W'(ONE_Q16)) ? LVL_W'(ONE_Q16) : sm_c;
    end
    if (cmd.out_load) begin
      adj_dn_r <= ovs_r;
    end
  end

  // Frame and sensitivity state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      ovs_r   <= 1'b0;
      phase_r <= '0;
      sens_r  <= RST_SENS;
      flag_r  <= 1'b1;
    end else begin
      if (cmd.sm3 && cfg.auto_on && sm_c > LVL_W'(ONE_Q16)) begin
        ovs_r <= 1'b1;
      end
      if (cmd.out_load) begin
        if (last_r) begin
          pos_r <= '0;
          ovs_r <= 1'b0;
          if (cfg.auto_on) begin
            phase_r <= roll ? 2'd0 : phase_inc;
          end
        end else begin
          pos_r <= pos_r + IW'(1);
        end
      end
      if (cmd.adj_apply) begin
        if (adj_dn_r) begin
          sens_r <= adj_s;
          flag_r <= 1'b0;
        end else begin
          sens_r <= flag_r ? adj_dbl : adj_s;
        end
      end
      if (cfg_wr.sens_ld) begin
        sens_r <= cfg_wr.data;
      end
      if (cfg_wr.flag_ld) begin
        flag_r <= cfg_wr.data[0];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_lvl_r <= stat.gain_one ? y_r : sat_q16(prod_r);
      out_num_r <= pos_r;
      out_end_r <= last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_bar_level  = out_lvl_r;
  assign out_bar_number = 8'(out_num_r);
  assign out_frame_end  = out_end_r;

endmodule

// File: sv/bgsa_checker.sv
module bgsa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_bar_level
);

  // A stalled result keeps its level.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bar_level))
    else $error("stalled result changed");

  // One bar at a time: an accepted transaction closes the input.
  a_one_bar: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input open while a bar is in work");

  // A new result is written only from the final step, never while idle.
  a_new_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared from the idle state");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bar_gravity_smoothing_autogain_unit bgsa_checker u_bgsa_checker (.*);

// File: bench/tb_bar_gravity_smoothing_autogain_unit.sv
`timescale 1ns / 100ps

module tb_bar_gravity_smoothing_autogain_unit;
  import bgsa_pkg::*;

  localparam int MAX_BARS    = 256;
  localparam int LIMIT_CYCLE = 1000000;
  localparam int SETTLE      = 20;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [31:0] level;
    logic [7:0]  number;
    logic        last_bar;
  } bar_result_t;

  // Scoreboard: mirrors the bar pipeline and holds the levels still owed.
  class bar_level_scoreboard;
    bar_result_t owed[$];
    int          errors;
    bit [8:0]    bar_count;
    bit          auto_on;
    bit [15:0]   weight;
    bit [23:0]   gravity;
    bit [31:0]   gain;
    bit [31:0]   sens;
    bit          start_flag;
    bit [1:0]    frame_phase;
    bit          overshoot;
    int          position;
    bit [63:0]   peak[MAX_BARS];
    bit [63:0]   fall[MAX_BARS];
    bit [63:0]   prev_raw[MAX_BARS];
    bit [63:0]   memory[MAX_BARS];

    function new();
      errors = 0;
      bar_count = RST_BAR_COUNT;
      auto_on = 1'b1;
      weight = RST_WEIGHT;
      gravity = RST_GRAVITY;
      gain = RST_GAIN;
      sens = RST_SENS;
      start_flag = 1'b1;
      frame_phase = 2'd0;
      overshoot = 1'b0;
      position = 0;
      foreach (peak[i]) begin
        peak[i] = 0;
        fall[i] = 0;
        prev_raw[i] = 0;
        memory[i] = 0;
      end
    endfunction

    // Q16.16 product, truncated and saturated to 32 bits.
    function bit [63:0] q16_mul_sat(bit [63:0] a, bit [63:0] b);
      bit [63:0] p;
      p = (a * b) >> 16;
      return (p > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : p;
    endfunction

    function void write_reg(reg_idx_t idx, bit [31:0] data);
      case (idx)
        REG_BAR_COUNT:   bar_count = data[8:0];
        REG_AUTO_GAIN:   auto_on = data[0];
        REG_WEIGHT:      weight = data[15:0];
        REG_GRAVITY:     gravity = data[23:0];
        REG_OUT_GAIN:    gain = data;
        REG_START_SENS:  sens = data;
        REG_START_PHASE: start_flag = data[0];
        default: ;
      endcase
    endfunction

    // Work out the level of one accepted bar and queue it.
    function void note_bar(bit [31:0] energy, bit sig);
      bit [63:0]   x, f, t, g;
      int          count, k;
      bit          last_bar;
      bar_result_t r;
      count = (bar_count == 9'd0) ? 1 : int'(bar_count);
      if (count > MAX_BARS) count = MAX_BARS;
      k = (position >= MAX_BARS) ? MAX_BARS - 1 : position;
      last_bar = (k + 1) >= count;
      g = (gravity < 24'd65536) ? 64'd65536 : 64'(gravity);

      x = 64'(energy);
      if (auto_on) x = q16_mul_sat(x, 64'(sens));

      // A falling bar drops from its held peak under gravity.
      if (x < prev_raw[k] && weight > WEIGHT_TENTH) begin
        f = fall[k];
        t = (((f * f) >> 16) * g) >> 16;
        x = (t >= 64'd65536) ? 64'd0 : (peak[k] * (64'd65536 - t)) >> 16;
        f = f + 64'(FALL_STEP);
        fall[k] = (f > 64'd65535) ? 64'd65535 : f;
      end else begin
        peak[k] = x;
        fall[k] = 0;
      end
      prev_raw[k] = x;

      // First-order smoothing, then the silence floor and the clamp at one.
      x = (memory[k] * 64'(weight) + x * (64'd65536 - 64'(weight))) >> 16;
      if (x > 64'hFFFF_FFFF) x = 64'hFFFF_FFFF;
      memory[k] = x;
      if (!sig && x < 64'(LEVEL_FLOOR)) begin
        x = 64'(LEVEL_FLOOR);
        memory[k] = 64'(LEVEL_FLOOR);
      end
      if (auto_on && x > 64'd65536) begin
        overshoot = 1'b1;
        x = 64'd65536;
      end

      // Sensitivity adapts every third frame end.
      if (last_bar) begin
        if (auto_on) begin
          frame_phase = frame_phase + 2'd1;
          if (frame_phase >= 2'd3) begin
            frame_phase = 2'd0;
            if (overshoot) begin
              sens = 32'(q16_mul_sat(64'(sens), 64'(SENS_DOWN)));
              start_flag = 1'b0;
            end else if (sig) begin
              sens = 32'(q16_mul_sat(64'(sens), 64'(SENS_UP)));
              if (start_flag) sens = 32'(q16_mul_sat(64'(sens), 64'd131072));
            end
          end
        end
        overshoot = 1'b0;
        position = 0;
      end else begin
        position = k + 1;
      end

      if (gain != 32'd65536) x = q16_mul_sat(x, 64'(gain));
      r.level = x[31:0];
      r.number = k[7:0];
      r.last_bar = last_bar;
      owed.push_back(r);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(logic [31:0] level, logic [7:0] number, logic last_bar);
      bar_result_t r;
      if (owed.size() == 0) begin
        report_mismatch("unexpected transaction", level, 32'd0);
      end else begin
        r = owed.pop_front();
        if (level !== r.level) report_mismatch("bar_level", level, r.level);
        if (number !== r.number) report_mismatch("bar_number", 32'(number), 32'(r.number));
        if (last_bar !== r.last_bar) begin
          report_mismatch("frame_end", 32'(last_bar), 32'(r.last_bar));
        end
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_band_energy;
  logic        in_signal_present;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_bar_level;
  logic [7:0]  out_bar_number;
  logic        out_frame_end;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  bar_level_scoreboard sb;
  bit hold_request;
  int cycle_count;

  bar_gravity_smoothing_autogain_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_band_energy(in_band_energy), .in_signal_present(in_signal_present),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_bar_level(out_bar_level), .out_bar_number(out_bar_number),
    .out_frame_end(out_frame_end),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Clock, 10 ns period.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLE) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one, sometimes none at all.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int n;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      n = pick_gap();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Every accepted result goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_bar_level, out_bar_number, out_frame_end);
  end

  // Offer one bar and hold it until the transaction completes.
  task send_bar(logic [31:0] energy, logic sig);
    int n;
    n = pick_gap();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_band_energy <= energy;
    in_signal_present <= sig;
    do @(posedge clk); while (!in_ready);
    sb.note_bar(energy, sig);
  endtask

  // Let every owed result arrive, then let the block settle.
  task drain();
    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task write_reg(reg_idx_t idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task load_regs(logic [8:0] bc, logic ag, logic [15:0] w, logic [23:0] g,
                 logic [31:0] gain, logic [31:0] sens, logic phase);
    write_reg(REG_BAR_COUNT, 32'(bc));
    write_reg(REG_AUTO_GAIN, 32'(ag));
    write_reg(REG_WEIGHT, 32'(w));
    write_reg(REG_GRAVITY, 32'(g));
    write_reg(REG_OUT_GAIN, gain);
    write_reg(REG_START_SENS, sens);
    write_reg(REG_START_PHASE, 32'(phase));
    cfg_we <= 1'b0;
  endtask

  // Energy mix: mostly small values that rise and fall, some extremes.
  function automatic logic [31:0] pick_energy();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 32'd0;
    if (r < 13) return 32'hFFFF_FFFF;
    if (r < 25) return $urandom;
    return $urandom_range(0, 3000);
  endfunction

  task random_bars(int n);
    repeat (n) send_bar(pick_energy(), ($urandom_range(0, 9) != 0));
  endtask

  initial begin
    int i;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_band_energy = '0;
    in_signal_present = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_request = 1'b0;
    cycle_count = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: four bars per frame; extremes, a peak then falling bars.
    load_regs(9'd4, 1'b1, 16'd50463, 24'd131072, 32'd65536, 32'd6553600, 1'b1);
    send_bar(32'hFFFF_FFFF, 1'b1);
    send_bar(32'd0, 1'b0);
    send_bar(32'd1, 1'b1);
    send_bar(32'd1000, 1'b1);
    for (i = 0; i < 12; i++) send_bar((i < 4) ? 32'd900 : 32'd0, i[0]);
    drain();

    // Lowering the count mid-frame: ten bars of sixteen, then a count of three.
    load_regs(9'd16, 1'b0, 16'd6554, 24'd0, 32'd0, 32'd0, 1'b0);
    for (i = 0; i < 10; i++) send_bar(32'd70000 - 32'(i * 5000), 1'b0);
    drain();
    load_regs(9'd3, 1'b1, 16'd30000, 24'd65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    random_bars(60);
    drain();

    // Count of zero acts as one; the receiver holds off while bars keep coming.
    load_regs(9'd0, 1'b1, 16'd65535, 24'hFF_FFFF, 32'd65536, 32'd6553600, 1'b1);
    hold_request = 1'b1;
    random_bars(120);
    drain();

    // Count above the bar store; weight at the gravity threshold, so no bar falls.
    load_regs(9'd511, 1'b1, WEIGHT_TENTH, 24'd131072, 32'd131072, 32'd100, 1'b0);
    random_bars(300);
    drain();

    load_regs(9'd256, 1'b0, 16'd0, 24'd65536, 32'd32768, 32'd6553600, 1'b1);
    random_bars(260);
    drain();

    // Random settings, mostly short frames.
    for (i = 0; i < 10; i++) begin
      load_regs(9'($urandom_range(1, 12)), $urandom_range(0, 3) != 0,
                16'($urandom_range(0, 65535)), 24'($urandom_range(65536, 400000)),
                ($urandom_range(0, 1) != 0) ? 32'd65536 : 32'($urandom_range(0, 300000)),
                32'($urandom_range(6553, 13107200)), $urandom_range(0, 1) != 0);
      random_bars(60);
      drain();
    end

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
